// ===== rtl/smm_pkg.sv =====
// Shared constants, types and arithmetic helpers for the square matrix multiplier.
package smm_pkg;

   // Sizing
   localparam int MAX_N        = 8;
   localparam int OPERAND_BITS = 16;
   localparam int IDX_W        = $clog2(MAX_N);
   localparam int A_DEPTH      = MAX_N * MAX_N;
   localparam int A_AW         = $clog2(A_DEPTH);
   localparam int ACC_W        = 40;

   // Fixed port field widths
   localparam int SIZE_W       = 4;
   localparam int IN_IDX_W     = 3;
   localparam int OUT_IDX_W    = 3;
   localparam int RAW_W        = 16;
   localparam int REQ_W        = 40;
   localparam int RSP_W        = 48;
   localparam int RSP_PAD      = RSP_W - 2 * OUT_IDX_W - ACC_W;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Operand token handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic                    last;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        k;
      logic [OPERAND_BITS-1:0] a;
   } tok_type;

   // Finished product element from one cell
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [ACC_W-1:0] value;
   } res_type;

   // Raw 16-bit field to stored operand width (zero fill or truncate)
   function automatic logic [OPERAND_BITS-1:0] fit_operand(input logic [RAW_W-1:0] v);
      logic [OPERAND_BITS+RAW_W-1:0] wide;
      wide = {{OPERAND_BITS{1'b0}}, v};
      return wide[OPERAND_BITS-1:0];
   endfunction

   // Signed product, sign-extended or wrapped to accumulator width
   function automatic logic [ACC_W-1:0] mul_ext(input logic [OPERAND_BITS-1:0] a,
                                                input logic [OPERAND_BITS-1:0] b);
      logic signed [2*OPERAND_BITS-1:0]       p;
      logic signed [2*OPERAND_BITS+ACC_W-1:0] w;
      p = signed'(a) * signed'(b);
      w = p;
      return w[ACC_W-1:0];
   endfunction

endpackage

// ===== rtl/smm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/smm_seq.sv =====
// Sequencer: holds matrix A and walks row/k, feeding operand tokens into the cell chain.
module smm_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                start,
   input  logic                                final_taken,
   input  logic [smm_pkg::IDX_W-1:0]           n_m1,
   input  logic                                wr_en,
   input  logic [smm_pkg::A_AW-1:0]            wr_addr,
   input  logic [smm_pkg::OPERAND_BITS-1:0]    wr_data,
   output logic                                busy,
   output smm_pkg::tok_type                    tok
);

   smm_pkg::state_type               state_ff, state_in;
   logic [smm_pkg::IDX_W-1:0]        i_ff, i_in;
   logic [smm_pkg::IDX_W-1:0]        k_ff, k_in;
   logic                             issue;
   logic                             last_k;
   logic                             last_i;
   logic [smm_pkg::A_AW-1:0]         rd_addr;
   logic [smm_pkg::OPERAND_BITS-1:0] a_rd;
   logic                             tok_valid_ff;
   logic                             tok_first_ff;
   logic                             tok_last_ff;
   logic [smm_pkg::IDX_W-1:0]        tok_row_ff;
   logic [smm_pkg::IDX_W-1:0]        tok_k_ff;

   assign last_k  = (k_ff == n_m1);
   assign last_i  = (i_ff == n_m1);
   assign rd_addr = smm_pkg::A_AW'(int'(i_ff) * smm_pkg::MAX_N + int'(k_ff));

   // Matrix A store, addressed row * MAX_N + col
   smm_ram #(
      .WIDTH (smm_pkg::OPERAND_BITS),
      .DEPTH (smm_pkg::A_DEPTH)
   ) u_a_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (a_rd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (start) state_in = smm_pkg::ST_RUN;
         end
         smm_pkg::ST_RUN: begin
            if (adv && last_i && last_k) state_in = smm_pkg::ST_DRAIN;
         end
         smm_pkg::ST_DRAIN: begin
            if (final_taken) state_in = smm_pkg::ST_IDLE;
         end
         default: begin
            state_in = smm_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      issue = 1'b0;
      busy  = 1'b1;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         smm_pkg::ST_RUN: begin
            issue = 1'b1;
         end
         smm_pkg::ST_DRAIN: begin
            issue = 1'b0;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Row / k counters
   always_comb begin
      i_in = i_ff;
      k_in = k_ff;
      if (start) begin
         i_in = '0;
         k_in = '0;
      end else if (adv && issue) begin
         if (last_k) begin
            k_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smm_pkg::ST_IDLE;
         i_ff         <= '0;
         k_ff         <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         if (adv) tok_valid_ff <= issue;
      end
   end

   // Token fields line up with the registered A read
   always_ff @(posedge clock) begin
      if (adv) begin
         tok_first_ff <= (k_ff == '0);
         tok_last_ff  <= last_k;
         tok_row_ff   <= i_ff;
         tok_k_ff     <= k_ff;
      end
   end

   always_comb begin
      tok.valid = tok_valid_ff;
      tok.first = tok_first_ff;
      tok.last  = tok_last_ff;
      tok.row   = tok_row_ff;
      tok.k     = tok_k_ff;
      tok.a     = a_rd;
   end

endmodule

// ===== rtl/smm_cell.sv =====
// One column cell: holds a column of B, multiplies passing A tokens and accumulates C.
module smm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             wr_en,
   input  logic [smm_pkg::IDX_W-1:0]        wr_addr,
   input  logic [smm_pkg::OPERAND_BITS-1:0] wr_data,
   input  smm_pkg::tok_type                 tok_in,
   output smm_pkg::tok_type                 tok_out,
   output smm_pkg::res_type                 res
);

   smm_pkg::tok_type                 t1_ff;
   logic [smm_pkg::OPERAND_BITS-1:0] b_rd;
   logic                             pv_ff;
   logic                             pfirst_ff;
   logic                             plast_ff;
   logic [smm_pkg::IDX_W-1:0]        prow_ff;
   logic [smm_pkg::ACC_W-1:0]        prod_ff;
   logic                             done_ff;
   logic [smm_pkg::IDX_W-1:0]        drow_ff;
   logic [smm_pkg::ACC_W-1:0]        acc_ff, acc_in;

   // Column of B, read at the token's k
   smm_ram #(
      .WIDTH (smm_pkg::OPERAND_BITS),
      .DEPTH (smm_pkg::MAX_N)
   ) u_b_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (adv),
      .rd_addr (tok_in.k),
      .rd_data (b_rd)
   );

   // Accumulate, restarting on the first k of a row
   assign acc_in = pfirst_ff ? prod_ff : acc_ff + prod_ff;

   // Token stage, product stage, accumulator stage; reset clears the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         pv_ff       <= 1'b0;
         done_ff     <= 1'b0;
      end else if (adv) begin
         t1_ff       <= tok_in;
         pv_ff       <= t1_ff.valid;
         done_ff     <= pv_ff && plast_ff;
         pfirst_ff   <= t1_ff.first;
         plast_ff    <= t1_ff.last;
         prow_ff     <= t1_ff.row;
         prod_ff     <= smm_pkg::mul_ext(t1_ff.a, b_rd);
         drow_ff     <= prow_ff;
         if (pv_ff) acc_ff <= acc_in;
      end
   end

   assign tok_out   = t1_ff;
   assign res.valid = done_ff;
   assign res.row   = drow_ff;
   assign res.value = acc_ff;

endmodule

// ===== rtl/square_matrix_multiply.sv =====
// Throughput: one request per cycle while loading; the product burst runs n*n k steps, and
//   C elements stream out one per cycle while the receiver holds rsp_tready high.
// The chain of MAX_N column cells sets this: one A element enters the chain per cycle unless the output stalls.
// No request is taken from the final load until the last C element has been taken.
// Reset clears control and sets matrix_size to 8; the A/B stores are undefined until written.
module square_matrix_multiply (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration: matrix_size
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [smm_pkg::SIZE_W-1:0]  csr_data,
   // Load requests
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [smm_pkg::REQ_W-1:0]   req_tdata,  // row_index, col_index, a_value, b_value, pad
   input  logic                        req_tlast,  // load_done
   // Product elements
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [smm_pkg::RSP_W-1:0]   rsp_tdata,  // out_row, out_col, c_value, pad
   output logic                        rsp_tlast   // final_result
);

   logic [smm_pkg::SIZE_W-1:0]       size_ff;
   logic [smm_pkg::SIZE_W-1:0]       eff_n;
   logic [smm_pkg::IDX_W-1:0]        n_m1;
   logic                             adv;
   logic                             busy;
   logic                             accept;
   logic                             start;
   logic                             final_taken;
   logic [smm_pkg::IN_IDX_W-1:0]     in_row;
   logic [smm_pkg::IN_IDX_W-1:0]     in_col;
   logic                             in_range;
   logic [smm_pkg::A_AW-1:0]         a_wr_addr;
   logic [smm_pkg::OPERAND_BITS-1:0] a_fit;
   logic [smm_pkg::OPERAND_BITS-1:0] b_fit;
   smm_pkg::tok_type                 tok_link [smm_pkg::MAX_N+1];
   smm_pkg::tok_type                 cell_in  [smm_pkg::MAX_N];
   smm_pkg::res_type                 res      [smm_pkg::MAX_N];
   logic [smm_pkg::MAX_N-1:0]        sel_vec;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_last_ff, out_last_in;
   logic [smm_pkg::IDX_W-1:0]        out_row_ff, out_row_in;
   logic [smm_pkg::IDX_W-1:0]        out_col_ff, out_col_in;
   logic [smm_pkg::ACC_W-1:0]        out_val_ff, out_val_in;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= smm_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   // Clamp size to 1..MAX_N
   always_comb begin
      if (size_ff == '0) begin
         eff_n = smm_pkg::SIZE_W'(1);
      end else if (size_ff > smm_pkg::SIZE_W'(smm_pkg::MAX_N)) begin
         eff_n = smm_pkg::SIZE_W'(smm_pkg::MAX_N);
      end else begin
         eff_n = size_ff;
      end
   end

   assign n_m1 = smm_pkg::IDX_W'(eff_n - smm_pkg::SIZE_W'(1));

   // Request side
   assign req_tready  = !busy;
   assign accept      = req_tvalid && req_tready;
   assign start       = accept && req_tlast;
   assign in_row      = req_tdata[2:0];
   assign in_col      = req_tdata[5:3];
   assign a_fit       = smm_pkg::fit_operand(req_tdata[21:6]);
   assign b_fit       = smm_pkg::fit_operand(req_tdata[37:22]);
   assign in_range    = (int'(in_row) < smm_pkg::MAX_N) && (int'(in_col) < smm_pkg::MAX_N);
   assign a_wr_addr   = smm_pkg::A_AW'(int'(in_row) * smm_pkg::MAX_N + int'(in_col));

   // Whole datapath moves unless the output register is full and stalled
   assign adv         = !out_valid_ff || rsp_tready;
   assign final_taken = rsp_tvalid && rsp_tready && rsp_tlast;

   smm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .start       (start),
      .final_taken (final_taken),
      .n_m1        (n_m1),
      .wr_en       (accept && in_range),
      .wr_addr     (a_wr_addr),
      .wr_data     (a_fit),
      .busy        (busy),
      .tok         (tok_link[0])
   );

   // Column cells; tokens stop at the first cell beyond the matrix size
   for (genvar j = 0; j < smm_pkg::MAX_N; j++) begin : g_cell
      always_comb begin
         cell_in[j]       = tok_link[j];
         cell_in[j].valid = tok_link[j].valid && (smm_pkg::SIZE_W'(j) < eff_n);
      end

      smm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .wr_en   (accept && in_range && (int'(in_col) == j)),
         .wr_addr (smm_pkg::IDX_W'(in_row)),
         .wr_data (b_fit),
         .tok_in  (cell_in[j]),
         .tok_out (tok_link[j+1]),
         .res     (res[j])
      );

      assign sel_vec[j] = res[j].valid;
   end

   // Collect the one finishing cell
   always_comb begin
      out_valid_in = 1'b0;
      out_row_in   = '0;
      out_col_in   = '0;
      out_val_in   = '0;
      for (int j = 0; j < smm_pkg::MAX_N; j++) begin
         if (res[j].valid) begin
            out_valid_in = 1'b1;
            out_row_in   = out_row_in | res[j].row;
            out_col_in   = out_col_in | smm_pkg::IDX_W'(j);
            out_val_in   = out_val_in | res[j].value;
         end
      end
      out_last_in = out_valid_in && (out_row_in == n_m1) && (out_col_in == n_m1);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_last_ff <= out_last_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_val_ff  <= out_val_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{smm_pkg::RSP_PAD{1'b0}}, out_val_ff,
                        smm_pkg::OUT_IDX_W'(out_col_ff), smm_pkg::OUT_IDX_W'(out_row_ff)};

   // Checks
   a_one_cell_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one cell finished in a cycle");

   a_no_load_while_results: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("load request open while results pending");

   a_idle_after_final: assert property (@(posedge clock) disable iff (reset)
      final_taken |=> req_tready)
      else $error("block not idle after final result");

   a_no_result_after_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_tvalid)
      else $error("result appeared right after a load");

   a_tail_only_busy: assert property (@(posedge clock) disable iff (reset)
      tok_link[smm_pkg::MAX_N].valid |-> busy)
      else $error("token in chain while sequencer idle");

endmodule

// ===== tb/sv/square_matrix_multiply_tb.sv =====
// Self-checking testbench for the square matrix multiplier: element loads, C bursts and sizes.
module square_matrix_multiply_tb;

   // One expected C element
   typedef struct packed {
      logic [smm_pkg::OUT_IDX_W-1:0] row;
      logic [smm_pkg::OUT_IDX_W-1:0] col;
      logic [smm_pkg::ACC_W-1:0]     c;
      logic                          last;
   } c_elem_type;

   // One row of the directed stimulus table
   typedef struct {
      bit                           set_size;
      logic [smm_pkg::SIZE_W-1:0]   size;
      logic [smm_pkg::IN_IDX_W-1:0] row;
      logic [smm_pkg::IN_IDX_W-1:0] col;
      logic [smm_pkg::RAW_W-1:0]    a;
      logic [smm_pkg::RAW_W-1:0]    b;
      bit                           done;
      bit                           typed;
      logic [smm_pkg::ACC_W-1:0]    c;
   } dir_row_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [smm_pkg::SIZE_W-1:0]   csr_data;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [smm_pkg::REQ_W-1:0]    req_tdata;
   logic                         req_tlast;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [smm_pkg::RSP_W-1:0]    rsp_tdata;
   logic                         rsp_tlast;

   // Shadow copy of the operand stores and the active size
   logic [smm_pkg::RAW_W-1:0]    a_mem [smm_pkg::MAX_N*smm_pkg::MAX_N];
   logic [smm_pkg::RAW_W-1:0]    b_mem [smm_pkg::MAX_N*smm_pkg::MAX_N];
   int                           eff_size;

   c_elem_type                   pending_c [$];
   dir_row_type                  dir_tab [$];
   int                           mismatches;
   int                           rand_loads;
   bit                           rsp_hold;
   bit                           no_gaps;

   square_matrix_multiply u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Operand mix: extremes often, random otherwise
   function automatic logic [smm_pkg::RAW_W-1:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Size mix: mostly small, a few large, some out of range
   function automatic logic [smm_pkg::SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 15);
      if (r < 10) return smm_pkg::SIZE_W'($urandom_range(1, 4));
      else if (r < 13) return smm_pkg::SIZE_W'($urandom_range(5, 8));
      else if (r == 13) return '0;
      else return smm_pkg::SIZE_W'($urandom_range(9, 15));
   endfunction

   // Full C = A*B over the active corner, row-major, exact 40-bit sums
   task automatic push_products();
      c_elem_type         e;
      logic signed [39:0] acc;
      logic signed [31:0] p;
      for (int i = 0; i < eff_size; i++) begin
         for (int j = 0; j < eff_size; j++) begin
            acc = '0;
            for (int k = 0; k < eff_size; k++) begin
               p   = $signed(a_mem[i*smm_pkg::MAX_N+k]) * $signed(b_mem[k*smm_pkg::MAX_N+j]);
               acc = acc + p;
            end
            e.row  = smm_pkg::OUT_IDX_W'(i);
            e.col  = smm_pkg::OUT_IDX_W'(j);
            e.c    = acc;
            e.last = (i == eff_size - 1) && (j == eff_size - 1);
            pending_c.push_back(e);
         end
      end
   endtask

   task automatic add_row(input bit set_size, input logic [smm_pkg::SIZE_W-1:0] size,
                          input logic [2:0] row, input logic [2:0] col,
                          input logic [15:0] a, input logic [15:0] b, input bit done,
                          input bit typed, input logic [smm_pkg::ACC_W-1:0] c);
      dir_row_type d;
      d.set_size = set_size;
      d.size     = size;
      d.row      = row;
      d.col      = col;
      d.a        = a;
      d.b        = b;
      d.done     = done;
      d.typed    = typed;
      d.c        = c;
      dir_tab.push_back(d);
   endtask

   // Drive one load request and update the shadow stores once taken
   task automatic send_req(input logic [2:0] row, input logic [2:0] col,
                           input logic [15:0] a, input logic [15:0] b, input bit done,
                           input bit typed, input logic [smm_pkg::ACC_W-1:0] c);
      int         gap;
      c_elem_type e;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, b, a, col, row};
      req_tlast  <= done;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      a_mem[{row, col}] = a;
      b_mem[{row, col}] = b;
      if (done) begin
         if (typed) begin
            e.row  = '0;
            e.col  = '0;
            e.c    = c;
            e.last = 1'b1;
            pending_c.push_back(e);
         end else begin
            push_products();
         end
      end
   endtask

   // Stop offering, let every expected element arrive, then cover the pipeline tail
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_c.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_size(input logic [smm_pkg::SIZE_W-1:0] v);
      wait_drained();
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eff_size = (v == 0) ? 1 : (v > smm_pkg::MAX_N) ? smm_pkg::MAX_N : int'(v);
   endtask

   // Stimulus
   initial begin : stimulus
      int                  nl;
      logic [2:0]          r;
      logic [2:0]          c;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      eff_size   = smm_pkg::MAX_N;
      mismatches = 0;
      rand_loads = 0;
      rsp_hold   = 1'b0;
      no_gaps    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Fill every store entry; the final load multiplies at the reset size of 8
      for (int p = 0; p < smm_pkg::MAX_N * smm_pkg::MAX_N; p++)
         send_req(p[5:3], p[2:0], rand_operand(), rand_operand(),
                  p == smm_pkg::MAX_N * smm_pkg::MAX_N - 1, 1'b0, '0);

      // Directed table: extremes, size clamps, unused loads, no-final loads
      add_row(1, 4'd1,  3'd0, 3'd0, 16'h7FFF, 16'h7FFF, 1, 1, 40'h003FFF0001);
      add_row(0, 4'd0,  3'd0, 3'd0, 16'h8000, 16'h8000, 1, 1, 40'h0040000000);
      add_row(0, 4'd0,  3'd0, 3'd0, 16'h8000, 16'h7FFF, 1, 1, 40'hFFC0008000);
      add_row(0, 4'd0,  3'd0, 3'd0, 16'h0000, 16'hFFFF, 1, 1, 40'h0000000000);
      add_row(0, 4'd0,  3'd0, 3'd0, 16'hFFFF, 16'hFFFF, 1, 1, 40'h0000000001);
      add_row(1, 4'd0,  3'd0, 3'd0, 16'h1234, 16'h0002, 1, 1, 40'h0000002468);
      add_row(0, 4'd0,  3'd7, 3'd7, 16'h7FFF, 16'h8000, 0, 0, '0);
      add_row(0, 4'd0,  3'd5, 3'd3, 16'h8000, 16'h8000, 1, 1, 40'h0000002468);
      add_row(1, 4'd15, 3'd2, 3'd6, 16'h7FFF, 16'h8000, 1, 0, '0);
      add_row(1, 4'd9,  3'd7, 3'd0, 16'h8000, 16'h7FFF, 1, 0, '0);
      add_row(1, 4'd2,  3'd1, 3'd1, 16'h8000, 16'h8000, 0, 0, '0);
      add_row(0, 4'd0,  3'd0, 3'd1, 16'h7FFF, 16'h7FFF, 0, 0, '0);
      add_row(0, 4'd0,  3'd1, 3'd0, 16'h8000, 16'h7FFF, 0, 0, '0);
      add_row(0, 4'd0,  3'd0, 3'd0, 16'h7FFF, 16'h8000, 1, 0, '0);
      add_row(1, 4'd8,  3'd3, 3'd4, 16'h5555, 16'hAAAA, 0, 0, '0);
      add_row(0, 4'd0,  3'd4, 3'd3, 16'hAAAA, 16'h5555, 1, 0, '0);
      add_row(1, 4'd3,  3'd2, 3'd2, 16'hFFFF, 16'h0001, 1, 0, '0);
      add_row(1, 4'd7,  3'd6, 3'd6, 16'h0001, 16'hFFFF, 1, 0, '0);
      for (int t = 0; t < dir_tab.size(); t++) begin
         if (dir_tab[t].set_size) write_size(dir_tab[t].size);
         send_req(dir_tab[t].row, dir_tab[t].col, dir_tab[t].a, dir_tab[t].b,
                  dir_tab[t].done, dir_tab[t].typed, dir_tab[t].c);
      end

      // Backpressure: receiver stalls long while loads keep coming after a final
      write_size(4'd8);
      rsp_hold = 1'b1;
      for (int q = 0; q < 4; q++)
         send_req(3'($urandom), 3'($urandom), rand_operand(), rand_operand(), q == 3,
                  1'b0, '0);
      for (int q = 0; q < 8; q++)
         send_req(3'($urandom), 3'($urandom), rand_operand(), rand_operand(), 1'b0,
                  1'b0, '0);
      wait_drained();

      // Random load sequences, each closed by a final load
      while (rand_loads < 126) begin
         if ($urandom_range(0, 2) == 0) write_size(pick_size());
         no_gaps = ($urandom_range(0, 5) == 0);
         nl = $urandom_range(0, (eff_size * eff_size < 12) ? eff_size * eff_size : 12);
         for (int q = 0; q < nl; q++) begin
            if ($urandom_range(0, 5) == 0) begin
               r = 3'($urandom);
               c = 3'($urandom);
            end else begin
               r = 3'($urandom_range(0, eff_size - 1));
               c = 3'($urandom_range(0, eff_size - 1));
            end
            send_req(r, c, rand_operand(), rand_operand(), 1'b0, 1'b0, '0);
         end
         send_req(3'($urandom), 3'($urandom), rand_operand(), rand_operand(), 1'b1,
                  1'b0, '0);
         rand_loads += nl + 1;
      end

      no_gaps = 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_c.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Result side: random stalls, one long hold on request, compare against expectations
   initial begin : rsp_side
      int            wait_c;
      c_elem_type    exp_e;
      logic [2:0]    got_row;
      logic [2:0]    got_col;
      logic [39:0]   got_c;
      logic          got_last;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            wait_c = no_gaps ? 0 : $urandom_range(0, 5);
            if (wait_c > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_c) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got_row  = rsp_tdata[2:0];
         got_col  = rsp_tdata[5:3];
         got_c    = rsp_tdata[45:6];
         got_last = rsp_tlast;
         if (pending_c.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected C element: row %0d col %0d c %h last %b",
                        got_row, got_col, got_c, got_last);
         end else begin
            exp_e = pending_c.pop_front();
            if (got_row !== exp_e.row || got_col !== exp_e.col || got_c !== exp_e.c ||
                got_last !== exp_e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"C mismatch: exp row %0d col %0d c %h last %b, ",
                            "got row %0d col %0d c %h last %b"},
                           exp_e.row, exp_e.col, exp_e.c, exp_e.last,
                           got_row, got_col, got_c, got_last);
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
